// ===== src/dat_pkg.sv =====
// Shared types and constants for the delivery ack tracker.
package dat_pkg;

    localparam logic [2:0] FUNC_SEND = 3'd0;
    localparam logic [2:0] FUNC_RECV = 3'd1;
    localparam logic [2:0] FUNC_EMIT = 3'd2;
    localparam logic [2:0] FUNC_ACK  = 3'd3;
    localparam logic [2:0] FUNC_TICK = 3'd4;

    localparam logic [1:0] KIND_DONE = 2'd0;
    localparam logic [1:0] KIND_OK   = 2'd1;
    localparam logic [1:0] KIND_FAIL = 2'd2;

    localparam logic [31:0] ACK_TIMEOUT_RESET = 32'd60000;
    localparam logic [15:0] LEN_MAX = 16'hFFFF;

    // Sequence width; the word fields carry exactly this many bits.
    localparam int SEQ_BITS = 16;

    typedef struct packed {
        logic [2:0]  func;
        logic [15:0] rx_seq;
        logic        ack_present;
        logic [15:0] ack_first;
        logic [15:0] ack_len;
        logic [31:0] now;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] seq_out;
        logic        accepted;
        logic        has_acks;
        logic [15:0] range_first;
        logic [15:0] range_len;
        logic        overflow;
        logic [31:0] dispatched_total;
        logic [31:0] delivered_total;
        logic [31:0] dropped_total;
        logic        last;
    } t_out_word;

endpackage

// ===== src/dat_cmp.sv =====
// Shared compare unit: one wide unsigned less-than and equality per cycle.
module dat_cmp (
    input  logic [32:0] i_a,
    input  logic [32:0] i_b,
    output logic        o_lt,
    output logic        o_eq
);
    assign o_lt = i_a < i_b;
    assign o_eq = i_a == i_b;
endmodule

// ===== src/delivery_ack_tracker.sv =====
// Top level of the delivery ack tracker: sequencer, queues and counters.
//
// Delivery ack tracker. One input word is taken when the block is idle, and the block is
// not ready again until the completion word (last=1) of that item has been taken. A send,
// receive, emit or unused code steps through accept, memory read, compare and result,
// completion taken. An ack-receive or tick item walks the in-flight queue from its head;
// each walk step is read, compare on the single shared comparator, then notice or cursor
// move, and output stalls can hold a notice or the completion word. A cursor jump to a
// later head is a step without a notice, and a tick that stops at a live entry ends after
// that last check in the notice state. Both queues live in memories with registered
// reads; their contents are undefined until written and no clearing pass is needed. The
// ack timeout register is written on its own channel while the block is idle, and a
// timeout write wins over an input word offered in the same cycle; the walk's timeout
// limit is now - ack_timeout, and a tick with now below the timeout retires nothing.
module delivery_ack_tracker #(
    parameter int FLIGHT_DEPTH = 32,
    parameter int PEND_DEPTH   = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  dat_pkg::t_in_word  i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output dat_pkg::t_out_word o_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [31:0]        i_cfg_data
);
    localparam int SEQ_BITS = dat_pkg::SEQ_BITS;
    localparam int FW = $clog2(FLIGHT_DEPTH);
    localparam int PW = $clog2(PEND_DEPTH);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_EVAL = 3'd2;
    localparam logic [2:0] S_NOTE = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;
    localparam logic [2:0] S_WAIT = 3'd5;

    logic [2:0] r_state;
    dat_pkg::t_in_word r_in;
    logic [31:0] r_timeout;
    logic [SEQ_BITS-1:0] r_send_seq, r_exp_seq;
    logic [FW-1:0] r_fhead;
    logic [FW:0]   r_fused;
    logic [PW-1:0] r_phead;
    logic [PW:0]   r_pused;
    logic [31:0] r_sent, r_ok, r_fail;
    logic [32:0] r_cur, r_end;
    logic [31:0] r_limit;
    logic r_out_valid;
    dat_pkg::t_out_word r_out;

    // Memories, registered reads.
    logic [SEQ_BITS-1:0] m_fseq  [FLIGHT_DEPTH];
    logic [31:0]         m_ftime [FLIGHT_DEPTH];
    logic [15:0]         m_pfirst[PEND_DEPTH];
    logic [15:0]         m_plen  [PEND_DEPTH];
    logic [SEQ_BITS-1:0] r_fseq_rd;
    logic [31:0]         r_ftime_rd;
    logic [15:0]         r_pfirst_rd, r_plen_rd;

    // Queue pointers wrap at the depth, which need not be a power of two.
    logic [FW:0]   f_sum;
    logic [FW-1:0] f_tail, f_head_nx;
    logic [PW:0]   p_sum, p_lsum;
    logic [PW-1:0] p_last, p_tail, p_rd_addr, p_head_nx;
    assign f_sum = (FW+1)'(r_fhead) + r_fused;
    assign f_tail = (f_sum >= (FW+1)'(FLIGHT_DEPTH)) ?
                    FW'(f_sum - (FW+1)'(FLIGHT_DEPTH)) : FW'(f_sum);
    assign f_head_nx = (r_fhead == FW'(FLIGHT_DEPTH - 1)) ? '0 : r_fhead + 1'b1;
    assign p_sum = (PW+1)'(r_phead) + r_pused;
    assign p_lsum = p_sum - 1'b1;
    assign p_tail = (p_sum >= (PW+1)'(PEND_DEPTH)) ?
                    PW'(p_sum - (PW+1)'(PEND_DEPTH)) : PW'(p_sum);
    assign p_last = (p_lsum >= (PW+1)'(PEND_DEPTH)) ?
                    PW'(p_lsum - (PW+1)'(PEND_DEPTH)) : PW'(p_lsum);
    assign p_head_nx = (r_phead == PW'(PEND_DEPTH - 1)) ? '0 : r_phead + 1'b1;
    assign p_rd_addr = (r_in.func == dat_pkg::FUNC_EMIT) ? r_phead : p_last;

    // Shared comparator; operands depend on the item.
    logic [32:0] c_a, c_b;
    logic c_lt, c_eq;
    always_comb begin
        unique case (r_in.func)
            dat_pkg::FUNC_ACK: begin
                c_a = 33'(r_fseq_rd);
                c_b = r_cur;
            end
            dat_pkg::FUNC_TICK: begin
                // entry check in the notice step, now against the timeout elsewhere
                if (r_state == S_NOTE) begin
                    c_a = 33'(r_ftime_rd);
                    c_b = 33'(r_limit);
                end else begin
                    c_a = 33'(r_in.now);
                    c_b = 33'(r_timeout);
                end
            end
            dat_pkg::FUNC_RECV: begin
                c_a = 33'(r_pfirst_rd) + 33'(r_plen_rd);
                c_b = 33'(r_in.rx_seq[SEQ_BITS-1:0]);
            end
            default: begin
                c_a = 33'(r_in.now);
                c_b = 33'(r_timeout);
            end
        endcase
    end
    dat_cmp u_cmp (.i_a(c_a), .i_b(c_b), .o_lt(c_lt), .o_eq(c_eq));

    assign o_ready     = (r_state == S_IDLE) && !i_cfg_valid;
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_valid     = r_out_valid;
    assign o_data      = r_out;

    logic out_free;
    assign out_free = !r_out_valid || i_ready;

    logic walk_more;
    assign walk_more = (r_fused != '0) && (r_in.func == dat_pkg::FUNC_TICK ||
                       (r_cur < r_end));

    always_ff @(posedge i_clk) begin
        r_fseq_rd   <= m_fseq[r_fhead];
        r_ftime_rd  <= m_ftime[r_fhead];
        r_pfirst_rd <= m_pfirst[p_rd_addr];
        r_plen_rd   <= m_plen[p_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_timeout <= dat_pkg::ACK_TIMEOUT_RESET;
            r_send_seq <= '0;
            r_exp_seq <= '0;
            r_fhead <= '0;
            r_fused <= '0;
            r_phead <= '0;
            r_pused <= '0;
            r_sent <= '0;
            r_ok <= '0;
            r_fail <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_timeout <= i_cfg_data;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_in <= i_data;
                        r_cur <= 33'(i_data.ack_first[SEQ_BITS-1:0]);
                        r_end <= 33'(i_data.ack_first[SEQ_BITS-1:0]) + 33'(i_data.ack_len);
                        r_limit <= i_data.now - r_timeout;
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    // read data settles this cycle
                    r_state <= S_EVAL;
                end
                S_EVAL: begin
                    if (out_free) begin
                        r_out <= '0;
                        r_state <= S_WAIT;
                        r_out_valid <= 1'b1;
                        r_out.last <= 1'b1;
                        unique case (r_in.func)
                            dat_pkg::FUNC_SEND: begin
                                r_out.seq_out <= 16'(r_send_seq);
                                r_out.dispatched_total <= r_sent;
                                r_out.delivered_total <= r_ok;
                                r_out.dropped_total <= r_fail;
                                if (r_fused == (FW+1)'(FLIGHT_DEPTH)) begin
                                    r_out.overflow <= 1'b1;
                                end else begin
                                    m_fseq[f_tail] <= r_send_seq;
                                    m_ftime[f_tail] <= r_in.now;
                                    r_fused <= r_fused + 1'b1;
                                    r_send_seq <= r_send_seq + 1'b1;
                                    r_sent <= r_sent + 1'b1;
                                    r_out.dispatched_total <= r_sent + 1'b1;
                                end
                            end
                            dat_pkg::FUNC_RECV: begin
                                r_out.seq_out <= 16'(r_in.rx_seq[SEQ_BITS-1:0]);
                                r_out.dispatched_total <= r_sent;
                                r_out.delivered_total <= r_ok;
                                r_out.dropped_total <= r_fail;
                                if (r_in.rx_seq[SEQ_BITS-1:0] >= r_exp_seq) begin
                                    r_out.accepted <= 1'b1;
                                    r_exp_seq <= r_in.rx_seq[SEQ_BITS-1:0] + 1'b1;
                                    if (r_pused != '0 && c_eq &&
                                        r_plen_rd != dat_pkg::LEN_MAX) begin
                                        m_plen[p_last] <= r_plen_rd + 1'b1;
                                    end else if (r_pused == (PW+1)'(PEND_DEPTH)) begin
                                        r_out.overflow <= 1'b1;
                                    end else begin
                                        m_pfirst[p_tail] <= 16'(r_in.rx_seq[SEQ_BITS-1:0]);
                                        m_plen[p_tail] <= 16'd1;
                                        r_pused <= r_pused + 1'b1;
                                    end
                                end
                            end
                            dat_pkg::FUNC_EMIT: begin
                                r_out.dispatched_total <= r_sent;
                                r_out.delivered_total <= r_ok;
                                r_out.dropped_total <= r_fail;
                                if (r_pused != '0) begin
                                    r_out.has_acks <= 1'b1;
                                    r_out.range_first <= r_pfirst_rd;
                                    r_out.range_len <= r_plen_rd;
                                    r_phead <= p_head_nx;
                                    r_pused <= r_pused - 1'b1;
                                end
                            end
                            dat_pkg::FUNC_ACK, dat_pkg::FUNC_TICK: begin
                                // walk step: notice or advance, else finish;
                                // a tick goes on only while now >= timeout
                                r_out_valid <= 1'b0;
                                r_state <= S_DONE;
                                if (walk_more && (r_in.func == dat_pkg::FUNC_ACK ?
                                        r_in.ack_present : !c_lt)) begin
                                    r_state <= S_NOTE;
                                end
                            end
                            default: begin
                                r_out.dispatched_total <= r_sent;
                                r_out.delivered_total <= r_ok;
                                r_out.dropped_total <= r_fail;
                            end
                        endcase
                    end
                end
                S_NOTE: begin
                    // one entry of the walk; head read data is current
                    if (out_free) begin
                        r_out <= '0;
                        r_out.seq_out <= 16'(r_fseq_rd);
                        r_out.dispatched_total <= r_sent;
                        r_out.delivered_total <= r_ok;
                        r_out.dropped_total <= r_fail;
                        r_state <= S_DONE;
                        if (r_in.func == dat_pkg::FUNC_TICK) begin
                            if (c_lt) begin
                                r_out_valid <= 1'b1;
                                r_out.kind <= dat_pkg::KIND_FAIL;
                                r_out.dropped_total <= r_fail + 1'b1;
                                r_fail <= r_fail + 1'b1;
                                r_fhead <= f_head_nx;
                                r_fused <= r_fused - 1'b1;
                                r_state <= S_READ;
                            end
                        end else if (c_lt) begin
                            r_out_valid <= 1'b1;
                            r_out.kind <= dat_pkg::KIND_FAIL;
                            r_out.dropped_total <= r_fail + 1'b1;
                            r_fail <= r_fail + 1'b1;
                            r_fhead <= f_head_nx;
                            r_fused <= r_fused - 1'b1;
                            r_state <= S_READ;
                        end else if (c_eq) begin
                            r_out_valid <= 1'b1;
                            r_out.kind <= dat_pkg::KIND_OK;
                            r_out.delivered_total <= r_ok + 1'b1;
                            r_ok <= r_ok + 1'b1;
                            r_fhead <= f_head_nx;
                            r_fused <= r_fused - 1'b1;
                            r_cur <= r_cur + 1'b1;
                            r_state <= S_READ;
                        end else begin
                            r_cur <= 33'(r_fseq_rd);
                            r_state <= S_READ;
                        end
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out <= '0;
                        r_out.dispatched_total <= r_sent;
                        r_out.delivered_total <= r_ok;
                        r_out.dropped_total <= r_fail;
                        r_out.last <= 1'b1;
                        r_out_valid <= 1'b1;
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    // hold until the completion word is taken
                    if (r_out_valid && i_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Walk re-entry: after a notice the head moved, so the read state refetches it.
    // A tick compares now with the timeout in every EVAL and entry times in NOTE.

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !o_valid)
        else $error("ready while a word is pending");
    a_fused_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fused <= (FW+1)'(FLIGHT_DEPTH))
        else $error("in-flight count beyond depth");
    a_pused_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pused <= (PW+1)'(PEND_DEPTH))
        else $error("pending count beyond depth");
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_data.last) |=> (r_state == S_IDLE))
        else $error("not idle after completion word");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the delivery ack tracker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FDEPTH = 32;
    localparam int PDEPTH = 16;
    localparam int CYCLE_LIMIT = 900000;

    // Expected-result store and predicted tracker state.
    class delivery_board;
        dat_pkg::t_out_word pending_words[$];
        int          errors;
        logic [31:0] timeout;
        logic [15:0] send_seq, expect_seq;
        logic [15:0] fl_seq [FDEPTH];
        logic [31:0] fl_stamp [FDEPTH];
        int          fl_head, fl_used;
        logic [15:0] rg_first [PDEPTH];
        logic [15:0] rg_len [PDEPTH];
        int          rg_head, rg_used;
        logic [31:0] n_sent, n_ok, n_fail;

        function new();
            errors = 0;
            timeout = dat_pkg::ACK_TIMEOUT_RESET;
            send_seq = '0;
            expect_seq = '0;
            fl_head = 0;
            fl_used = 0;
            rg_head = 0;
            rg_used = 0;
            n_sent = '0;
            n_ok = '0;
            n_fail = '0;
        endfunction

        function void push_word(logic [1:0] kind, logic [15:0] seq, logic acc,
                                logic has, logic [15:0] rf, logic [15:0] rl,
                                logic ovf, logic lst);
            dat_pkg::t_out_word w;
            w.kind = kind;
            w.seq_out = seq;
            w.accepted = acc;
            w.has_acks = has;
            w.range_first = rf;
            w.range_len = rl;
            w.overflow = ovf;
            w.dispatched_total = n_sent;
            w.delivered_total = n_ok;
            w.dropped_total = n_fail;
            w.last = lst;
            pending_words.push_back(w);
        endfunction

        // Merge an accepted sequence into the range queue; return 1 on overflow.
        function logic merge_range(logic [15:0] seq);
            int t;
            if (rg_used > 0) begin
                t = (rg_head + rg_used - 1) % PDEPTH;
                if ({1'b0, rg_first[t]} + {1'b0, rg_len[t]} == {1'b0, seq} &&
                    rg_len[t] < dat_pkg::LEN_MAX) begin
                    rg_len[t] = rg_len[t] + 16'd1;
                    return 1'b0;
                end
            end
            if (rg_used >= PDEPTH) return 1'b1;
            t = (rg_head + rg_used) % PDEPTH;
            rg_first[t] = seq;
            rg_len[t] = 16'd1;
            rg_used++;
            return 1'b0;
        endfunction

        function logic [15:0] pop_flight();
            logic [15:0] s;
            s = fl_seq[fl_head];
            fl_head = (fl_head + 1) % FDEPTH;
            fl_used--;
            return s;
        endfunction

        // Note one accepted input word and predict its results.
        function void note_input(dat_pkg::t_in_word w);
            int t;
            logic ovf;
            logic [16:0] cur, stop;
            logic [15:0] ps;
            logic [31:0] lim;
            case (w.func)
                dat_pkg::FUNC_SEND: begin
                    if (fl_used >= FDEPTH) begin
                        push_word(dat_pkg::KIND_DONE, send_seq, 0, 0, 0, 0, 1, 1);
                    end else begin
                        t = (fl_head + fl_used) % FDEPTH;
                        fl_seq[t] = send_seq;
                        fl_stamp[t] = w.now;
                        fl_used++;
                        n_sent = n_sent + 32'd1;
                        push_word(dat_pkg::KIND_DONE, send_seq, 0, 0, 0, 0, 0, 1);
                        send_seq = send_seq + 16'd1;
                    end
                end
                dat_pkg::FUNC_RECV: begin
                    if (w.rx_seq >= expect_seq) begin
                        expect_seq = w.rx_seq + 16'd1;
                        ovf = merge_range(w.rx_seq);
                        push_word(dat_pkg::KIND_DONE, w.rx_seq, 1, 0, 0, 0, ovf, 1);
                    end else begin
                        push_word(dat_pkg::KIND_DONE, w.rx_seq, 0, 0, 0, 0, 0, 1);
                    end
                end
                dat_pkg::FUNC_EMIT: begin
                    if (rg_used > 0) begin
                        push_word(dat_pkg::KIND_DONE, 0, 0, 1, rg_first[rg_head],
                                  rg_len[rg_head], 0, 1);
                        rg_head = (rg_head + 1) % PDEPTH;
                        rg_used--;
                    end else begin
                        push_word(dat_pkg::KIND_DONE, 0, 0, 0, 0, 0, 0, 1);
                    end
                end
                dat_pkg::FUNC_ACK: begin
                    if (w.ack_present) begin
                        cur = {1'b0, w.ack_first};
                        stop = {1'b0, w.ack_first} + {1'b0, w.ack_len};
                        while (cur < stop && fl_used > 0) begin
                            ps = fl_seq[fl_head];
                            if ({1'b0, ps} < cur) begin
                                ps = pop_flight();
                                n_fail = n_fail + 32'd1;
                                push_word(dat_pkg::KIND_FAIL, ps, 0, 0, 0, 0, 0, 0);
                            end else if ({1'b0, ps} == cur) begin
                                ps = pop_flight();
                                n_ok = n_ok + 32'd1;
                                push_word(dat_pkg::KIND_OK, ps, 0, 0, 0, 0, 0, 0);
                                cur = cur + 17'd1;
                            end else begin
                                cur = {1'b0, ps};
                            end
                        end
                    end
                    push_word(dat_pkg::KIND_DONE, 0, 0, 0, 0, 0, 0, 1);
                end
                dat_pkg::FUNC_TICK: begin
                    if (w.now >= timeout) begin
                        lim = w.now - timeout;
                        while (fl_used > 0 && fl_stamp[fl_head] < lim) begin
                            ps = pop_flight();
                            n_fail = n_fail + 32'd1;
                            push_word(dat_pkg::KIND_FAIL, ps, 0, 0, 0, 0, 0, 0);
                        end
                    end
                    push_word(dat_pkg::KIND_DONE, 0, 0, 0, 0, 0, 0, 1);
                end
                default: push_word(dat_pkg::KIND_DONE, 0, 0, 0, 0, 0, 0, 1);
            endcase
        endfunction

        // Compare one result word against the oldest expectation.
        function void check_result(dat_pkg::t_out_word got);
            dat_pkg::t_out_word exp_w;
            if (pending_words.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                errors++;
                return;
            end
            exp_w = pending_words[0];
            pending_words.delete(0);
            if (got !== exp_w) begin
                $display("%0t: mismatch, expected %h, actual %h", $time, exp_w, got);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    dat_pkg::t_in_word  in_word;
    logic        out_valid;
    logic        out_ready;
    dat_pkg::t_out_word out_word;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_word;

    delivery_board board;
    int          cycles;
    logic [31:0] clock_now;

    delivery_ack_tracker #(.FLIGHT_DEPTH(FDEPTH), .PEND_DEPTH(PDEPTH)) DUT (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_valid(in_valid),
        .o_ready(in_ready),
        .i_data(in_word),
        .o_valid(out_valid),
        .i_ready(out_ready),
        .o_data(out_word),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_data(cfg_word)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Cycle counter and watchdog.
    initial begin
        cycles = 0;
        forever begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Receiver: check each word on acceptance, then stall for a random gap before the next.
    initial begin
        int gap;
        out_ready = 1'b0;
        forever begin
            @(posedge clk);
            if (out_valid && out_ready) begin
                board.check_result(out_word);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
                if (gap > 0) begin
                    out_ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                    out_ready <= 1'b1;
                end
            end else if (rst_n) begin
                out_ready <= 1'b1;
            end
        end
    end

    // Send one word: idle a random gap, raise valid, hold until accepted.
    // Valid stays high after acceptance only when the next word follows at once.
    task automatic drive_word(dat_pkg::t_in_word w);
        int gap;
        gap = $urandom_range(0, 8);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_word <= w;
        in_valid <= 1'b1;
        do @(posedge clk); while (!(in_valid && in_ready));
        board.note_input(w);
    endtask

    task automatic send_item(logic [2:0] f, logic [15:0] rx, logic pres,
                             logic [15:0] af, logic [15:0] al, logic [31:0] tnow);
        dat_pkg::t_in_word w;
        w.func = f;
        w.rx_seq = rx;
        w.ack_present = pres;
        w.ack_first = af;
        w.ack_len = al;
        w.now = tnow;
        drive_word(w);
    endtask

    // Drain expectations, let the block settle, then write the timeout.
    task automatic write_timeout(logic [31:0] val);
        in_valid <= 1'b0;
        while (board.pending_words.size() != 0) @(posedge clk);
        repeat (120) @(posedge clk);
        cfg_word <= val;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!(cfg_valid && cfg_ready));
        board.timeout = val;
        cfg_valid <= 1'b0;
    endtask

    // Random item, mostly protocol-like traffic around the current state.
    task automatic random_item();
        int pick;
        logic [15:0] s;
        pick = $urandom_range(0, 99);
        clock_now = clock_now + $urandom_range(0, 3000);
        if (pick < 30) begin
            send_item(dat_pkg::FUNC_SEND, 16'($urandom), 1'($urandom), 16'($urandom),
                      16'($urandom), clock_now);
        end else if (pick < 50) begin
            s = ($urandom_range(0, 4) == 0) ? 16'($urandom) :
                16'(board.expect_seq + $urandom_range(0, 2) - 1);
            send_item(dat_pkg::FUNC_RECV, s, 1'($urandom), 16'($urandom), 16'($urandom),
                      $urandom);
        end else if (pick < 62) begin
            send_item(dat_pkg::FUNC_EMIT, 16'($urandom), 1'($urandom), 16'($urandom),
                      16'($urandom), $urandom);
        end else if (pick < 82) begin
            if (board.fl_used > 0 && $urandom_range(0, 3) != 0)
                s = 16'(board.fl_seq[board.fl_head] + $urandom_range(0, 3));
            else
                s = 16'($urandom);
            send_item(dat_pkg::FUNC_ACK, 16'($urandom), $urandom_range(0, 5) != 0, s,
                      ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6)),
                      $urandom);
        end else if (pick < 95) begin
            send_item(dat_pkg::FUNC_TICK, 16'($urandom), 1'($urandom), 16'($urandom),
                      16'($urandom), ($urandom_range(0, 6) == 0) ? $urandom : clock_now);
        end else begin
            send_item(3'($urandom_range(5, 7)), 16'($urandom), 1'($urandom), 16'($urandom),
                      16'($urandom), $urandom);
        end
    endtask

    initial begin
        board = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_word = '0;
        cfg_valid = 1'b0;
        cfg_word = '0;
        clock_now = 32'd0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: every function, old receive, empty emit, missing ack, early tick.
        send_item(dat_pkg::FUNC_EMIT, 0, 0, 0, 0, 0);
        send_item(dat_pkg::FUNC_SEND, 16'hFFFF, 1, 16'hFFFF, 16'hFFFF, 32'd0);
        send_item(dat_pkg::FUNC_SEND, 0, 0, 0, 0, 32'd10);
        send_item(dat_pkg::FUNC_SEND, 0, 0, 0, 0, 32'hFFFF_FFFF);
        send_item(dat_pkg::FUNC_RECV, 16'd5, 0, 0, 0, 0);
        send_item(dat_pkg::FUNC_RECV, 16'd6, 0, 0, 0, 0);
        send_item(dat_pkg::FUNC_RECV, 16'd2, 0, 0, 0, 0);
        send_item(dat_pkg::FUNC_RECV, 16'hFFFF, 0, 0, 0, 0);
        send_item(dat_pkg::FUNC_RECV, 16'd0, 0, 0, 0, 0);
        send_item(dat_pkg::FUNC_EMIT, 0, 0, 0, 0, 0);
        send_item(dat_pkg::FUNC_ACK, 0, 0, 16'd0, 16'd5, 0);
        send_item(dat_pkg::FUNC_ACK, 0, 1, 16'd1, 16'd1, 0);
        send_item(dat_pkg::FUNC_TICK, 0, 0, 0, 0, 32'd100);
        send_item(dat_pkg::FUNC_TICK, 0, 0, 0, 0, 32'hFFFF_FFFF);
        send_item(3'd5, 16'hFFFF, 1, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_item(3'd7, 0, 0, 0, 0, 0);
        // Fill the in-flight queue past its depth, then ack it all in one walk.
        repeat (FDEPTH + 2) send_item(dat_pkg::FUNC_SEND, 0, 0, 0, 0, 32'd500);
        send_item(dat_pkg::FUNC_ACK, 0, 1, 16'd0, 16'hFFFF, 0);
        // Overflow the range queue with gapped receives.
        for (int i = 0; i < PDEPTH + 2; i++)
            send_item(dat_pkg::FUNC_RECV, 16'(20 + 2 * i), 0, 0, 0, 0);
        repeat (PDEPTH + 1) send_item(dat_pkg::FUNC_EMIT, 0, 0, 0, 0, 0);

        write_timeout(32'd0);
        send_item(dat_pkg::FUNC_SEND, 0, 0, 0, 0, 32'd7);
        send_item(dat_pkg::FUNC_TICK, 0, 0, 0, 0, 32'd8);
        write_timeout(32'hFFFF_FFFF);
        send_item(dat_pkg::FUNC_SEND, 0, 0, 0, 0, 32'd1);
        send_item(dat_pkg::FUNC_TICK, 0, 0, 0, 0, 32'hFFFF_FFFF);
        send_item(dat_pkg::FUNC_TICK, 0, 0, 0, 0, 32'hFFFF_FFFE);

        // Random phases over several timeout settings.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: write_timeout(32'd5000);
                1: write_timeout(dat_pkg::ACK_TIMEOUT_RESET);
                2: write_timeout(32'd1);
                default: write_timeout($urandom_range(1000, 20000));
            endcase
            repeat (63) random_item();
        end
        // Walk sequences up to the top so the expected sequence wraps to zero.
        send_item(dat_pkg::FUNC_RECV, 16'hFFFE, 0, 0, 0, 0);
        send_item(dat_pkg::FUNC_RECV, 16'hFFFF, 0, 0, 0, 0);
        send_item(dat_pkg::FUNC_RECV, 16'd0, 0, 0, 0, 0);
        repeat (20) random_item();
        in_valid <= 1'b0;

        while (board.pending_words.size() != 0) @(posedge clk);
        repeat (150) @(posedge clk);
        if (board.errors == 0 && board.pending_words.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
